@@ rtl/core/mcht_pkg.sv @@
// ----------------------------------------------------------------------------
// Monotone convex hull trick: shared package
// Hull depth, field and line types, status codes and sequencer states.
// ----------------------------------------------------------------------------
package mcht_pkg;

  localparam int HULL_DEPTH = 1024;
  localparam int IDX_W      = $clog2(HULL_DEPTH);
  localparam int CNT_W      = $clog2(HULL_DEPTH + 1);
  localparam int NUM_W      = 49;
  localparam int DEN_W      = 33;
  localparam int QUO_W      = 64;

  localparam logic signed [QUO_W-1:0] NEG_INF = {1'b1, {(QUO_W-1){1'b0}}};

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_QUERY_OK = 3'd0,
    ST_ADDED    = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] slope;
    logic signed [47:0] intercept;
    logic signed [31:0] x_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] min_value;
    logic [2:0]         status;
    logic [10:0]        line_count;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0]      slope;
    logic signed [47:0]      intercept;
    logic signed [QUO_W-1:0] brk;
  } line_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_DUP,
    S_ADD_LOOP,
    S_LOOP_RD,
    S_LOOP_DIV,
    S_DIV_WAIT,
    S_LOOP_CHK,
    S_Q_RD0,
    S_Q_MUL,
    S_Q_ACC,
    S_Q_RD1,
    S_FIN
  } state_t;

endpackage

@@ rtl/core/monotone_convex_hull_trick_top.sv @@
// ----------------------------------------------------------------------------
// Monotone convex hull trick: top level
// Lower envelope of lines in a ring store, add and minimum-query items.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carries one item: an add (opcode 0) of a line
//   with decreasing slope, or a query (opcode 1) at non-decreasing x_coord.
//   out_valid/out_stall/out_data returns exactly one item per input item:
//   min_value, status and the number of lines held afterwards.
//   One item is worked at a time; in_stall is high while it runs.
//   Add: an empty hull or an ignored duplicate needs no crossing; else each
//   crossing computed runs the shared bit-serial divider (49 steps), but an
//   equal slope skips it. Pops are amortised. Query: front lines are examined
//   one after another through the single 32x32 multiplier and one read port
//   of the line store; an empty query reads no line.
//   A finished result waits in the output register; a new item is taken
//   meanwhile, and the sequencer only holds when a second result is ready.
//   Reset empties the hull at once; the store itself is never cleared.
// ----------------------------------------------------------------------------
module monotone_convex_hull_trick_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mcht_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mcht_pkg::out_item_t  out_data
);
  import mcht_pkg::*;

  line_t mem [HULL_DEPTH];

  state_t                  state_r, state_nxt;
  logic signed [31:0]      k_r;
  logic signed [47:0]      b_r;
  logic signed [31:0]      x_r;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  line_t                   rd_r;
  logic signed [63:0]      prod_r;
  logic signed [47:0]      bq_r;
  logic signed [63:0]      v0_r, v0_nxt;
  logic signed [63:0]      vsum;
  logic                    first_r, first_nxt;
  logic signed [QUO_W-1:0] q_r, q_nxt;
  out_item_t               res_r, res_nxt;
  out_item_t               out_r;
  logic                    out_valid_r;

  logic                    rd_en;
  logic [CNT_W-1:0]        rd_off;
  logic [IDX_W-1:0]        rd_idx;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;
  logic                    div_start;
  logic                    div_done;
  logic signed [QUO_W-1:0] div_quot;
  logic signed [NUM_W-1:0] num;
  logic signed [DEN_W-1:0] den;
  logic                    accept;
  logic                    out_free;

  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(HULL_DEPTH)) sum = sum - (CNT_W+1)'(HULL_DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign rd_idx   = slot(head_r, rd_off);
  assign wr_idx   = slot(head_r, n_r);
  assign num      = NUM_W'(rd_r.intercept) - NUM_W'(b_r);
  assign den      = DEN_W'(k_r) - DEN_W'(rd_r.slope);
  assign vsum     = prod_r + 64'(bq_r);

  mcht_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    v0_nxt    = v0_r;
    first_nxt = first_r;
    q_nxt     = q_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_off    = '0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          n_nxt             = cnt_r;
          res_nxt.min_value = '0;
          res_nxt.line_count = 11'(cnt_r);
          first_nxt         = 1'b1;
          if (in_data.opcode == OP_ADD) begin
            state_nxt = (cnt_r == '0) ? S_ADD_LOOP : S_ADD_RD;
          end else if (cnt_r == '0) begin
            res_nxt.status = ST_EMPTY;
            state_nxt      = S_FIN;
          end else begin
            state_nxt = S_Q_RD0;
          end
        end
      end
      S_ADD_RD: begin
        rd_en     = 1'b1;
        rd_off    = n_r - 1'b1;
        state_nxt = S_ADD_DUP;
      end
      S_ADD_DUP: begin
        if (rd_r.slope == k_r) begin
          if (rd_r.intercept < b_r) begin
            res_nxt.status = ST_DUP;
            state_nxt      = S_FIN;
          end else begin
            n_nxt     = n_r - 1'b1;
            state_nxt = S_ADD_LOOP;
          end
        end else begin
          state_nxt = S_ADD_LOOP;
        end
      end
      S_ADD_LOOP: begin
        if (n_r == '0) begin
          q_nxt     = NEG_INF;
          state_nxt = S_LOOP_CHK;
        end else begin
          state_nxt = S_LOOP_RD;
        end
      end
      S_LOOP_RD: begin
        rd_en     = 1'b1;
        rd_off    = n_r - 1'b1;
        state_nxt = S_LOOP_DIV;
      end
      S_LOOP_DIV: begin
        if (den == '0) begin
          q_nxt     = NEG_INF;
          state_nxt = S_LOOP_CHK;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          q_nxt     = div_quot;
          state_nxt = S_LOOP_CHK;
        end
      end
      S_LOOP_CHK: begin
        if (n_r > CNT_W'(1) && q_r <= rd_r.brk) begin
          n_nxt     = n_r - 1'b1;
          state_nxt = S_LOOP_RD;
        end else if (n_r >= CNT_W'(HULL_DEPTH)) begin
          res_nxt.status = ST_FULL;
          state_nxt      = S_FIN;
        end else begin
          wr_en              = 1'b1;
          cnt_nxt            = n_r + 1'b1;
          res_nxt.status     = ST_ADDED;
          res_nxt.line_count = 11'(n_r + 1'b1);
          state_nxt          = S_FIN;
        end
      end
      S_Q_RD0: begin
        rd_en     = 1'b1;
        rd_off    = '0;
        state_nxt = S_Q_MUL;
      end
      S_Q_RD1: begin
        rd_en     = 1'b1;
        rd_off    = CNT_W'(1);
        state_nxt = S_Q_MUL;
      end
      S_Q_MUL: begin
        state_nxt = S_Q_ACC;
      end
      S_Q_ACC: begin
        if (first_r) begin
          v0_nxt    = vsum;
          first_nxt = 1'b0;
        end else if (v0_r >= vsum) begin
          v0_nxt   = vsum;
          head_nxt = slot(head_r, CNT_W'(1));
          cnt_nxt  = cnt_r - 1'b1;
        end
        if (!first_r && v0_r < vsum) begin
          state_nxt = S_FIN;
        end else if (cnt_nxt > CNT_W'(1)) begin
          state_nxt = S_Q_RD1;
        end else begin
          state_nxt = S_FIN;
        end
        res_nxt.status     = ST_QUERY_OK;
        res_nxt.min_value  = v0_nxt;
        res_nxt.line_count = 11'(cnt_nxt);
      end
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k_r <= in_data.slope;
      b_r <= in_data.intercept;
      x_r <= in_data.x_coord;
    end
    n_r     <= n_nxt;
    v0_r    <= v0_nxt;
    first_r <= first_nxt;
    q_r     <= q_nxt;
    res_r   <= res_nxt;
    prod_r  <= rd_r.slope * x_r;
    bq_r    <= rd_r.intercept;
    if (state_r == S_FIN && out_free) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= mem[rd_idx];
    if (wr_en) mem[wr_idx] <= '{slope: k_r, intercept: b_r, brk: q_r};
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HULL_DEPTH))
    else $error("line count beyond hull depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (CNT_W+1)'(cnt_r) <= (CNT_W+1)'($past(cnt_r)) + 1'b1)
    else $error("line count grew by more than one");

  a_added_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ST_ADDED |-> out_r.line_count != '0)
    else $error("add reported with empty hull");

  a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ST_EMPTY |->
      out_r.min_value == '0 && out_r.line_count == '0)
    else $error("empty query result malformed");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

endmodule

@@ rtl/core/mcht_div.sv @@
// ----------------------------------------------------------------------------
// Monotone convex hull trick: floor divider
// Restoring division on magnitudes, one quotient bit per cycle, floor fix-up.
// ----------------------------------------------------------------------------
module mcht_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [mcht_pkg::NUM_W-1:0]   num,
  input  logic signed [mcht_pkg::DEN_W-1:0]   den,
  output logic                                done,
  output logic signed [mcht_pkg::QUO_W-1:0]   quot
);
  import mcht_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0]  rem_r;
  logic [NUM_W-1:0]  qm_r;
  logic [DEN_W-1:0]  dm_r;
  logic              neg_r;

  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    diff;
  logic              ge;
  logic [QUO_W-1:0]  qx;

  assign rem_sh = {rem_r, qm_r[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, dm_r};
  assign ge     = !diff[DEN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qm_r  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dm_r  <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      rem_r <= '0;
      neg_r <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      qm_r  <= {qm_r[NUM_W-2:0], ge};
    end
  end

  assign qx   = QUO_W'(qm_r);
  assign quot = neg_r ? $signed(~qx + QUO_W'(rem_r == '0)) : $signed(qx);
  assign done = done_r;

endmodule
